@@ sv/pbagc_pkg.sv @@
package pbagc_pkg;

   // Block geometry
   localparam int BINS    = 64;
   localparam int IDX_W   = $clog2(BINS);
   localparam int NSQ     = 12;            // squaring steps for the log2 fraction
   localparam int NST     = 10 + NSQ;      // pipeline stages ahead of the output register

   // Clamp limits and log offset
   localparam logic [31:0] GAIN_MIN = 32'd262;
   localparam logic [31:0] GAIN_MAX = 32'd2621440000;
   localparam logic [47:0] EPS_Q32  = 48'd4295;

   // Register reset values
   localparam logic [19:0] PREEMPH_RST = 20'd15360;
   localparam logic [15:0] NEW_W_RST   = 16'd3277;
   localparam logic [15:0] OLD_W_RST   = 16'd62259;
   localparam logic [15:0] KP_RST      = 16'd328;
   localparam logic [15:0] KD_RST      = 16'd66;

   typedef enum logic [2:0] {
      CSR_PREEMPH_STEP = 3'd0,
      CSR_NEW_WEIGHT   = 3'd1,
      CSR_OLD_WEIGHT   = 3'd2,
      CSR_PROP_GAIN    = 3'd3,
      CSR_DERIV_GAIN   = 3'd4
   } csr_reg_type;

   typedef struct packed {
      logic [IDX_W-1:0] bin_index;
      logic [15:0]      magnitude;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0] out_index;
      logic [31:0]      gained_sample;
      logic [31:0]      smoothed_level;
      logic [31:0]      new_gain;
   } rsp_type;

   // One entry of the per-bin state memory
   typedef struct packed {
      logic [31:0]        gain;
      logic [31:0]        level;
      logic signed [18:0] lerr;
   } mem_word_type;

   // Per-item data that rides along the pipeline
   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [31:0]        gained;
      logic [31:0]        level;
      logic [31:0]        gain;
      logic signed [18:0] lerr;
   } carry_type;

endpackage

@@ sv/per_bin_log_pd_gain_control_top.sv @@
// Per-bin gain control with a PD law on a log2 level error.
//
// Input channel (req_*): one spectrum bin per transfer, bin number plus
// Q8.8 magnitude. Result channel (rsp_*): one result per input transfer,
// carrying the bin number, gained sample, smoothed level and updated gain.
// Register port (csr_*): always ready; write only while the block is idle.
// Unknown register indexes are ignored.
//
// Throughput: one bin per cycle as long as rsp_stall does not freeze the
// pipeline and no item of the same bin is still in flight. The per-bin
// state sits in one memory read at input transfer and written when the item
// leaves the pipeline; an item whose bin is still in the pipeline is held by
// req_stall until the earlier item has written back.
//
// Reset clears the registers to defaults and marks all bin entries as zero
// (valid bits, no clearing pass). When rsp_stall is high while rsp_valid is
// high, the whole pipeline freezes and req_stall rises; nothing is dropped.
module per_bin_log_pd_gain_control_top import pbagc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [19:0] csr_data
);

   // Configuration registers
   logic [19:0] preemph_ff;
   logic [15:0] new_w_ff, old_w_ff, kp_ff, kd_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         preemph_ff <= PREEMPH_RST;
         new_w_ff   <= NEW_W_RST;
         old_w_ff   <= OLD_W_RST;
         kp_ff      <= KP_RST;
         kd_ff      <= KD_RST;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_PREEMPH_STEP: preemph_ff <= csr_data;
            CSR_NEW_WEIGHT:   new_w_ff   <= csr_data[15:0];
            CSR_OLD_WEIGHT:   old_w_ff   <= csr_data[15:0];
            CSR_PROP_GAIN:    kp_ff      <= csr_data[15:0];
            CSR_DERIV_GAIN:   kd_ff      <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // Pipeline control
   logic             adv;
   logic             hazard;
   logic             accept;
   logic [NST-1:0]   vld_ff;
   carry_type        car_ff [NST];
   carry_type        car_in [NST];
   logic             rsp_valid_ff;
   rsp_type          rsp_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;

   // Same-bin interlock against every item still in flight
   always_comb begin
      hazard = 1'b0;
      for (int k = 0; k < NST; k++) begin
         if (vld_ff[k] && car_ff[k].idx == req_data.bin_index) hazard = 1'b1;
      end
   end

   assign req_stall = !adv || hazard;
   assign accept    = req_valid && !req_stall;

   // State memory and its entry valid bits
   mem_word_type     mem [BINS];
   mem_word_type     rd_ff;
   logic [BINS-1:0]  vb_ff;
   logic             hit_ff;
   logic             wr_en;
   mem_word_type     wr_word;

   always_ff @(posedge clock) begin
      if (adv) rd_ff <= mem[req_data.bin_index];
      if (wr_en) mem[car_ff[NST-1].idx] <= wr_word;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff  <= '0;
         hit_ff <= 1'b0;
      end else begin
         if (adv) hit_ff <= vb_ff[req_data.bin_index];
         if (wr_en) vb_ff[car_ff[NST-1].idx] <= 1'b1;
      end
   end

   // Valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[NST-2:0], accept};
         rsp_valid_ff <= vld_ff[NST-1];
      end
   end

   // Arithmetic stage signals
   logic [15:0]        mag0_ff;
   logic [26:0]        fac0_ff;
   logic [42:0]        pre_prod;
   logic [31:0]        pre1_ff, pre_in;
   logic [63:0]        gain_prod;
   logic [31:0]        gained_in;
   logic [47:0]        pn3_ff, po3_ff;
   logic [48:0]        lvl_sum;
   logic [31:0]        level_in;
   logic [5:0]         msb;
   logic [5:0]         p_in;
   logic [47:0]        arg5_ff;
   logic [77:0]        norm;
   logic [30:0]        m_ff  [NSQ+1];
   logic [NSQ-1:0]     fr_ff [NSQ+1];
   logic [5:0]         p_ff  [NSQ+2];
   logic [61:0]        sq    [NSQ];
   logic [6:0]         pm32;
   logic signed [18:0] logv, e_in, e_ff;
   logic signed [19:0] d_in, d_ff;
   logic signed [35:0] pe_ff;
   logic signed [36:0] pd_ff;
   logic signed [37:0] s_ff;
   logic signed [27:0] u;
   logic signed [39:0] g;
   logic [31:0]        g_clamp;
   logic signed [18:0] e_ff_out;
   logic signed [18:0] e_pipe_ff [2];

   // Stage 1 and 2 products, level sum, leading-one search, mantissa normalization
   always_comb begin
      pre_prod  = 43'(mag0_ff) * 43'(fac0_ff);
      pre_in    = (|pre_prod[42:40]) ? '1 : pre_prod[39:8];
      gain_prod = 64'(pre1_ff) * 64'(car_ff[1].gain);
      gained_in = (|gain_prod[63:50]) ? '1 : gain_prod[49:18];
      lvl_sum   = 49'(pn3_ff) + 49'(po3_ff);
      level_in  = lvl_sum[48] ? '1 : lvl_sum[47:16];
      msb = '0;
      for (int i = 0; i < 32; i++) begin
         if (car_ff[4].level[i]) msb = 6'(i);
      end
      p_in = (car_ff[4].level == '0) ? 6'd12 : 6'd16 + msb;
      norm = {arg5_ff, 30'd0} >> p_ff[0];
   end

   // Squaring products
   always_comb begin
      for (int k = 0; k < NSQ; k++) sq[k] = 62'(m_ff[k]) * 62'(m_ff[k]);
   end

   // Next carry values: shift along, with fields filled in at their stages
   always_comb begin
      car_in[0]     = '0;
      car_in[0].idx = req_data.bin_index;
      for (int k = 1; k < NST; k++) car_in[k] = car_ff[k-1];
      // stage 1: state from memory
      car_in[1].gain   = hit_ff ? rd_ff.gain  : '0;
      car_in[1].level  = hit_ff ? rd_ff.level : '0;
      car_in[1].lerr   = hit_ff ? rd_ff.lerr  : '0;
      // stage 2: gained sample
      car_in[2].gained = gained_in;
      // stage 4: new level
      car_in[4].level  = level_in;
   end

   // Pipeline registers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NST; k++) car_ff[k] <= car_in[k];
         // stage 0: capture input and pre-emphasis factor
         mag0_ff <= req_data.magnitude;
         fac0_ff <= 27'd65536 + 27'(req_data.bin_index) * 27'(preemph_ff);
         // stage 1: pre-emphasized sample
         pre1_ff <= pre_in;
         // stage 3: IIR products
         pn3_ff <= 48'(new_w_ff) * 48'(car_ff[2].gained);
         po3_ff <= 48'(old_w_ff) * 48'(car_ff[2].level);
         // stage 5: log argument and its leading-one position
         arg5_ff  <= {car_ff[4].level, 16'd0} + EPS_Q32;
         p_ff[0]  <= p_in;
         // stage 6: normalized mantissa
         m_ff[0]  <= norm[30:0];
         fr_ff[0] <= '0;
         p_ff[1]  <= p_ff[0];
         // stages 7..18: one squaring each
         for (int k = 0; k < NSQ; k++) begin
            if (sq[k][61]) begin
               m_ff[k+1]  <= sq[k][61:31];
               fr_ff[k+1] <= {fr_ff[k][NSQ-2:0], 1'b1};
            end else begin
               m_ff[k+1]  <= sq[k][60:30];
               fr_ff[k+1] <= {fr_ff[k][NSQ-2:0], 1'b0};
            end
            p_ff[k+2] <= p_ff[k+1];
         end
         // stage 19: error and its difference
         e_ff <= e_in;
         d_ff <= d_in;
         // stage 20: PD products
         pe_ff <= $signed({1'b0, kp_ff}) * e_ff;
         pd_ff <= $signed({1'b0, kd_ff}) * d_ff;
         // stage 21: PD sum
         s_ff <= 38'(pe_ff) + 38'(pd_ff);
         // output register
         rsp_ff.out_index      <= car_ff[NST-1].idx;
         rsp_ff.gained_sample  <= car_ff[NST-1].gained;
         rsp_ff.smoothed_level <= car_ff[NST-1].level;
         rsp_ff.new_gain       <= g_clamp;
      end
   end

   // Error from the log2 result
   always_comb begin
      pm32 = 7'(p_ff[NSQ+1]) - 7'd32;
      logv = $signed({pm32, fr_ff[NSQ]});
      e_in = -logv;
      d_in = 20'(e_in) - 20'(car_ff[NSQ+6].lerr);
   end

   // Gain update with floor division and clamp
   always_comb begin
      u = 28'(s_ff >>> 10);
      g = $signed({8'd0, car_ff[NST-1].gain}) + 40'(u);
      priority if (g > $signed({8'd0, GAIN_MAX})) g_clamp = GAIN_MAX;
      else if (g < $signed({8'd0, GAIN_MIN}))     g_clamp = GAIN_MIN;
      else                                        g_clamp = g[31:0];
   end

   // Write back as the item leaves the pipeline
   assign wr_en         = adv && vld_ff[NST-1];
   assign wr_word.gain  = g_clamp;
   assign wr_word.level = car_ff[NST-1].level;
   assign wr_word.lerr  = e_ff_out;

   always_ff @(posedge clock) begin
      if (adv) begin
         e_pipe_ff[0] <= e_ff;
         e_pipe_ff[1] <= e_pipe_ff[0];
      end
   end

   assign e_ff_out = e_pipe_ff[1];

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.new_gain >= GAIN_MIN && rsp_data.new_gain <= GAIN_MAX)
      else $error("gain out of clamp range");

   a_vb_set: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> vb_ff[$past(car_ff[NST-1].idx)])
      else $error("written entry not marked valid");

   a_norm: assert property (@(posedge clock) disable iff (reset)
      vld_ff[6] |-> m_ff[0][30])
      else $error("mantissa not normalized");

   a_no_dup: assert property (@(posedge clock) disable iff (reset)
      accept |=> !(vld_ff[1] && car_ff[1].idx == car_ff[0].idx))
      else $error("same bin accepted twice in flight");

endmodule
